FILE: hw/rtl/cma_pkg.sv
package cma_pkg;

    localparam int MAX_SERIES  = 128;
    localparam int SAMPLE_BITS = 16;
    localparam int POS_W       = $clog2(MAX_SERIES);
    localparam int ACC_W       = 48;
    localparam int ACC_DEPTH   = MAX_SERIES * (MAX_SERIES + 1) / 2;
    localparam int ACC_AW      = $clog2(ACC_DEPTH);
    localparam int PROD_W      = 2 * SAMPLE_BITS;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [0:0] REG_NUM_SERIES = 1'd0;
    localparam logic [0:0] REG_INV_COUNT  = 1'd1;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SAMPLE,
        ST_DRAIN,
        ST_RD_ADDR,
        ST_RD_WAIT,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_FINAL
    } state_t;

endpackage

FILE: hw/rtl/cma_cell.sv
module cma_cell
    import cma_pkg::*;
(
    input  logic                          clk,
    input  logic                          shift,
    input  logic signed [SAMPLE_BITS-1:0] d,
    output logic signed [SAMPLE_BITS-1:0] q
);

    logic signed [SAMPLE_BITS-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= d;
        end
    end

    assign q = value_reg;

endmodule

FILE: hw/rtl/covariance_matrix_accumulate.sv
// Scaled Gram matrix accumulator.
// Input beats: s_axis_tuser carries the mode (sample, read, clear). A sample
// beat adds the products of its value with itself and the earlier samples of the
// same time point into the lower-triangle sums; series come in order 0 to n-1.
// A read beat returns one entry on the master side, scaled by inv_count,
// rounded and saturated, with tuser set when it was clipped. A clear beat
// zeroes the sums and the series position and gives no output beat.
// A sample rotates the stored samples once through a ring of cells, one per
// cycle; each earlier series and the sample itself cost one read-modify-write
// of the accumulator memory. A read passes the memory read and two partial
// products before its output beat; an entry outside the matrix skips them and
// reads as zero. The block is ready for the next beat in the same cycle that
// the output beat is raised. After reset, and after every clear beat, the block
// zeroes all ACC_DEPTH (8256) memory entries, one entry a cycle, and accepts no
// beat meanwhile. The output register holds a beat while the receiver stalls;
// the block then accepts the next beat but cannot finish another read until it
// drains. The user must write configuration through cfg_we/cfg_addr/cfg_wdata
// only while idle; the block leaves that check to the user.
module covariance_matrix_accumulate
    import cma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_value[15:0], row[22:16], col[29:23]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cov_value[31:0]
    output logic [0:0]  m_axis_tuser,   // saturated[0]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [32:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic [7:0]  num_series_reg;
    logic [32:0] inv_count_reg;

    logic [POS_W-1:0]  pos_reg, p_reg, j_reg;
    logic [ACC_AW-1:0] base_reg, abase_reg, clr_cnt_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [6:0] rr_reg, cc_reg;

    logic [ACC_W-1:0]  rdata_reg;
    logic              pend_reg;
    logic [ACC_AW-1:0] paddr_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic              neg_reg;
    logic [ACC_W-1:0]  mag_reg;
    logic [56:0]       hp_reg, lo_reg;

    logic        ovalid_reg;
    logic [31:0] cov_reg;
    logic        sat_reg;

    logic [ACC_W-1:0] acc_mem [ACC_DEPTH];

    logic [POS_W:0]  n_eff;
    logic [32:0]     k_eff;
    logic            accept;
    logic [1:0]      mode_in;
    logic [POS_W-1:0] p_use;
    logic [POS_W:0]  p_inc;
    logic [ACC_AW-1:0] base_use;
    logic            active_step, at_p, oor;
    logic [ACC_AW-1:0] raddr, tri_addr;
    logic [2*ACC_AW-1:0] tri_prod;
    logic signed [SAMPLE_BITS-1:0] head, feedback, mult_b;
    logic [81:0] total;
    logic [49:0] rnd;
    logic        out_free;

    logic signed [SAMPLE_BITS-1:0] cell_q [MAX_SERIES];

    assign n_eff = (num_series_reg == 8'd0) ? (POS_W+1)'(1) :
                   (32'(num_series_reg) > MAX_SERIES) ? (POS_W+1)'(MAX_SERIES) :
                   (POS_W+1)'(num_series_reg);
    assign k_eff = (inv_count_reg > ONE_Q32) ? ONE_Q32 : inv_count_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign mode_in = s_axis_tuser;

    assign p_use    = ({1'b0, pos_reg} >= n_eff) ? '0 : pos_reg;
    assign base_use = ({1'b0, pos_reg} >= n_eff) ? '0 : base_reg;
    assign p_inc    = {1'b0, p_use} + (POS_W+1)'(1);

    assign head     = cell_q[0];
    assign at_p     = (j_reg == p_reg);
    assign active_step = (state_reg == ST_SAMPLE) && (j_reg <= p_reg);
    assign feedback = (state_reg == ST_SAMPLE && at_p) ? x_reg : head;
    assign mult_b   = at_p ? x_reg : head;

    assign oor = ({1'b0, rr_reg} >= (8)'(n_eff)) || ({1'b0, cc_reg} >= (8)'(n_eff));
    assign tri_prod = ACC_AW'(rr_reg) * (ACC_AW'(rr_reg) + ACC_AW'(1));
    assign tri_addr = ACC_AW'(tri_prod >> 1) + ACC_AW'(cc_reg);
    assign raddr    = (state_reg == ST_SAMPLE) ? abase_reg + ACC_AW'(j_reg) : tri_addr;

    assign total = {1'b0, hp_reg, 24'd0} + {25'd0, lo_reg} + 82'h8000_0000;
    assign rnd   = total[81:32];
    assign out_free = !ovalid_reg || m_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SERIES; gi++)
        begin : g_cell
            logic signed [SAMPLE_BITS-1:0] d_in;
            if (gi == MAX_SERIES - 1)
            begin : g_last
                assign d_in = feedback;
            end
            else
            begin : g_mid
                assign d_in = cell_q[gi+1];
            end
            cma_cell u_cell (
                .clk   (clk),
                .shift (state_reg == ST_SAMPLE),
                .d     (d_in),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        rdata_reg <= acc_mem[raddr];
        if (state_reg == ST_CLEAR)
        begin
            acc_mem[clr_cnt_reg] <= '0;
        end
        else if (pend_reg)
        begin
            acc_mem[paddr_reg] <= rdata_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ACC_AW'(ACC_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode_in)
                        MODE_SAMPLE: state_next = ST_SAMPLE;
                        MODE_READ:   state_next = ST_RD_ADDR;
                        MODE_CLEAR:  state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SAMPLE:
            begin
                if (j_reg == POS_W'(MAX_SERIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:   state_next = ST_IDLE;
            ST_RD_ADDR: state_next = oor ? ST_FINAL : ST_RD_WAIT;
            ST_RD_WAIT: state_next = ST_MUL_HI;
            ST_MUL_HI:  state_next = ST_MUL_LO;
            ST_MUL_LO:  state_next = ST_FINAL;
            ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            num_series_reg <= 8'd1;
            inv_count_reg  <= ONE_Q32;
            pos_reg        <= '0;
            base_reg       <= '0;
            clr_cnt_reg    <= '0;
            j_reg          <= '0;
            pend_reg       <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= active_step;
            if (cfg_we)
            begin
                if (cfg_addr == REG_NUM_SERIES)
                begin
                    num_series_reg <= cfg_wdata[7:0];
                end
                else
                begin
                    inv_count_reg <= cfg_wdata;
                end
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ACC_AW'(1);
            end
            else
            begin
                clr_cnt_reg <= '0;
            end
            if (state_reg == ST_SAMPLE)
            begin
                j_reg <= j_reg + POS_W'(1);
            end
            else
            begin
                j_reg <= '0;
            end
            if (accept && mode_in == MODE_SAMPLE)
            begin
                if (p_inc >= n_eff)
                begin
                    pos_reg  <= '0;
                    base_reg <= '0;
                end
                else
                begin
                    pos_reg  <= p_inc[POS_W-1:0];
                    base_reg <= base_use + ACC_AW'(p_inc);
                end
            end
            else if (accept && mode_in == MODE_CLEAR)
            begin
                pos_reg  <= '0;
                base_reg <= '0;
            end
            if (state_reg == ST_FINAL && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= s_axis_tdata[SAMPLE_BITS-1:0];
            p_reg     <= p_use;
            abase_reg <= base_use;
            if (s_axis_tdata[22:16] >= s_axis_tdata[29:23])
            begin
                rr_reg <= s_axis_tdata[22:16];
                cc_reg <= s_axis_tdata[29:23];
            end
            else
            begin
                rr_reg <= s_axis_tdata[29:23];
                cc_reg <= s_axis_tdata[22:16];
            end
        end
        prod_reg  <= x_reg * mult_b;
        paddr_reg <= raddr;
        case (state_reg)
            ST_RD_ADDR:
            begin
                neg_reg <= 1'b0;
                hp_reg  <= '0;
                lo_reg  <= '0;
            end
            ST_RD_WAIT:
            begin
                neg_reg <= rdata_reg[ACC_W-1];
                mag_reg <= rdata_reg[ACC_W-1] ? (~rdata_reg + ACC_W'(1)) : rdata_reg;
            end
            ST_MUL_HI: hp_reg <= mag_reg[47:24] * k_eff;
            ST_MUL_LO: lo_reg <= mag_reg[23:0] * k_eff;
            ST_FINAL:
            begin
                if (out_free)
                begin
                    if (!neg_reg)
                    begin
                        if (rnd > 50'h7FFF_FFFF)
                        begin
                            cov_reg <= 32'h7FFF_FFFF;
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            cov_reg <= rnd[31:0];
                            sat_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        if (rnd > 50'h8000_0000)
                        begin
                            cov_reg <= 32'h8000_0000;
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            cov_reg <= ~rnd[31:0] + 32'd1;
                            sat_reg <= 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = cov_reg;
    assign m_axis_tuser  = sat_reg;

endmodule
